### rtl/pofn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pofn_pkg;

    localparam int ANGLE_WIDTH_DEF = 32;
    localparam int LANES           = 4;
    localparam int SINE_LAT        = 8;
    localparam int CYC_W           = 4;
    localparam int SUB2_START      = 5;
    localparam int COMMON_START    = 10;
    localparam int ISSUE_LAST      = 12;
    localparam int ACC_W           = 36;
    localparam int RESULT_LAT      = 13;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_FIRST_SHIFT  = 2'd0;
    localparam cfg_index_t CFG_SECOND_SHIFT = 2'd1;
    localparam cfg_index_t CFG_SECOND_GAIN  = 2'd2;

    // Taylor coefficients of sin(pi/2 x) in Q1.30, highest order first.
    localparam logic [30:0] SINE_COEF [0:5] = '{
        31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };

    localparam logic [31:0] DIV5_RECIP = 32'hCCCCCCCD;
    localparam int          ROUND_HALF = 160;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_SUB1,
        KIND_SUB2,
        KIND_ADD1,
        KIND_ADD2
    } kind_t;

    typedef struct packed {
        logic [31:0] phase_one;
        logic [31:0] phase_two;
        logic [31:0] phase_three;
        logic [31:0] phase_four;
    } item_t;

    typedef struct packed {
        logic signed [31:0] rate_one;
        logic signed [31:0] rate_two;
        logic signed [31:0] rate_three;
        logic signed [31:0] rate_four;
    } result_t;

    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        kind_t [LANES-1:0]        kind;
        logic [31:0]              gain;
    } tag_t;

    typedef struct packed {
        logic issuing;
        logic last_issue;
    } back_status_t;

endpackage

`default_nettype wire

### rtl/pofn_sine.sv
`timescale 1ns / 1ps
`default_nettype none

module pofn_sine
    import pofn_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic [ANGLE_WIDTH-1:0] angle,
    output logic signed [31:0]          sine
);

    localparam int W = ANGLE_WIDTH;

    logic [W-3:0]  frac;
    logic [W-2:0]  fold;
    logic [30:0]   x_comb;

    logic [30:0]   x_reg   [0:6];
    logic          neg_reg [0:6];
    logic [30:0]   x2_reg  [1:5];
    logic [30:0]   p_reg   [2:6];
    logic [61:0]   sq;
    logic [61:0]   prod    [2:6];
    logic [61:0]   fin_prod;
    logic [31:0]   mag;
    logic signed [31:0] sine_reg;

    assign frac = angle[W-3:0];
    assign fold = angle[W-2] ? ((W-1)'(1) << (W-2)) - {1'b0, frac} : {1'b0, frac};

    generate
        if (W >= 32)
        begin : g_narrow
            assign x_comb = 31'(fold >> (W-32));
        end
        else
        begin : g_widen
            assign x_comb = 31'(fold) << (32-W);
        end
    endgenerate

    assign sq = 62'(x_reg[0]) * 62'(x_reg[0]);
    assign prod[2] = 62'(x2_reg[1]) * 62'(SINE_COEF[0]);

    genvar k;
    generate
        for (k = 3; k <= 6; k++)
        begin : g_horner
            assign prod[k] = 62'(x2_reg[k-1]) * 62'(p_reg[k-1]);
        end
    endgenerate

    assign fin_prod = 62'(x_reg[6]) * 62'(p_reg[6]);
    assign mag      = {1'b0, fin_prod[60:30]};

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= x_comb;
        neg_reg[0] <= angle[W-1];
        for (int n = 1; n <= 6; n++)
        begin
            x_reg[n]   <= x_reg[n-1];
            neg_reg[n] <= neg_reg[n-1];
        end
        x2_reg[1] <= sq[60:30];
        for (int n = 2; n <= 5; n++)
        begin
            x2_reg[n] <= x2_reg[n-1];
        end
        for (int n = 2; n <= 6; n++)
        begin
            p_reg[n] <= SINE_COEF[n-1] - prod[n][60:30];
        end
        sine_reg <= neg_reg[6] ? -$signed(mag) : $signed(mag);
    end

    assign sine = sine_reg;

endmodule

`default_nettype wire

### rtl/pofn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pofn_front
    import pofn_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire item_t                      item,
    input  wire logic [31:0]                first_shift,
    input  wire logic [31:0]                second_shift,
    input  wire logic [31:0]                gain,
    input  wire logic                       q_full,
    output logic                            busy,
    output logic                            push,
    output logic [6*ANGLE_WIDTH+31:0]       push_data
);

    localparam int W  = ANGLE_WIDTH;
    localparam int QW = 6*W + 32;

    logic [31:0]   raw  [0:5];
    logic [W-1:0]  conv [0:5];
    logic          valid_reg, valid_next;
    logic [QW-1:0] entry_reg;
    logic          accept;

    assign raw[0] = item.phase_one;
    assign raw[1] = item.phase_two;
    assign raw[2] = item.phase_three;
    assign raw[3] = item.phase_four;
    assign raw[4] = first_shift;
    assign raw[5] = second_shift;

    genvar n;
    generate
        for (n = 0; n < 6; n++)
        begin : g_conv
            if (W >= 32)
            begin : g_up
                assign conv[n] = W'(raw[n]) << (W-32);
            end
            else
            begin : g_down
                assign conv[n] = W'(raw[n] >> (32-W));
            end
        end
    endgenerate

    assign busy   = valid_reg & q_full;
    assign accept = start & ~busy;
    assign push   = valid_reg & ~q_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= {conv[0], conv[1], conv[2], conv[3], conv[4], conv[5], gain};
        end
    end

    assign push_data = entry_reg;

endmodule

`default_nettype wire

### rtl/pofn_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pofn_queue
    import pofn_pkg::*;
#(
    parameter int WIDTH = 6*ANGLE_WIDTH_DEF + 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  empty,
    output logic [WIDTH-1:0]      pop_data
);

    logic [WIDTH-1:0] data_reg [0:1];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/pofn_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pofn_back
    import pofn_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_empty,
    input  wire logic [6*ANGLE_WIDTH+31:0]  q_data,
    output logic                            pop,
    output logic                            done,
    output result_t                         result,
    output back_status_t                    status
);

    localparam int W = ANGLE_WIDTH;

    logic                 cur_valid_reg, cur_valid_next;
    logic [CYC_W-1:0]     cyc_reg, cyc_next;
    logic [W-1:0]         g_reg [1:LANES];
    logic [W-1:0]         a_reg, b_reg;
    logic [31:0]          gain_reg;
    logic [W-1:0]         g_all [0:LANES];
    logic                 last_cyc;

    logic [W-1:0]         angle_lane [LANES];
    kind_t                kind_lane  [LANES];
    logic signed [31:0]   sine_lane  [LANES];

    tag_t                 tag_in;
    tag_t                 tag_reg [0:SINE_LAT-1];
    tag_t                 tag_out;

    logic signed [ACC_W-1:0] acc1_reg [LANES];
    logic signed [ACC_W-1:0] acc2_reg [LANES];
    logic signed [ACC_W-1:0] acc1_next [LANES];
    logic signed [ACC_W-1:0] acc2_next [LANES];
    logic signed [ACC_W-1:0] c1_reg, c2_reg, c1_next, c2_next;
    logic signed [ACC_W-1:0] contrib [LANES];

    logic                 fin0_reg, fin1_reg, fin2_reg, fin3_reg, done_reg;
    logic [31:0]          gain0_reg, gain1_reg;
    logic signed [ACC_W-1:0] s1_reg [LANES];
    logic signed [ACC_W-1:0] s2_reg [LANES];
    logic signed [ACC_W-1:0] s1b_reg [LANES];
    logic signed [51:0]   ph_reg [LANES];
    logic signed [52:0]   pl_reg [LANES];
    logic [31:0]          n_reg  [LANES];
    logic                 nneg_reg [LANES];
    logic signed [31:0]   res_reg [LANES];

    logic signed [55:0]   sum_c  [LANES];
    logic signed [55:0]   v_c    [LANES];
    logic [55:0]          mag_c  [LANES];
    logic [63:0]          q_c    [LANES];

    // Sequencer: steps through the issue cycles of each item, up to four sines per cycle.
    assign last_cyc = (cyc_reg == CYC_W'(ISSUE_LAST));
    assign pop      = ~q_empty & (~cur_valid_reg | last_cyc);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cyc_next       = cyc_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cyc_next       = '0;
        end
        else if (cur_valid_reg)
        begin
            if (last_cyc)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                cyc_next = cyc_reg + CYC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cyc_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cyc_reg       <= cyc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            g_reg[1] <= q_data[32+5*W +: W];
            g_reg[2] <= q_data[32+4*W +: W];
            g_reg[3] <= q_data[32+3*W +: W];
            g_reg[4] <= q_data[32+2*W +: W];
            a_reg    <= q_data[32+W +: W];
            b_reg    <= q_data[32 +: W];
            gain_reg <= q_data[31:0];
        end
    end

    assign g_all[0] = '0;
    genvar l;
    generate
        for (l = 1; l <= LANES; l++)
        begin : g_gall
            assign g_all[l] = g_reg[l];
        end
    endgenerate

    generate
        for (l = 0; l < LANES; l++)
        begin : g_lane
            logic [3:0]   k;
            logic [2:0]   j;
            logic [W-1:0] gj;
            logic [W-1:0] d1;

            assign k  = 4'((cyc_reg - CYC_W'(COMMON_START)) << 2) + 4'(l);
            assign gj = g_all[j];
            assign d1 = g_all[l+1] - gj;

            always_comb
            begin
                j            = '0;
                kind_lane[l] = KIND_NONE;
                angle_lane[l] = a_reg;
                if (cyc_reg < CYC_W'(SUB2_START))
                begin
                    j             = 3'(cyc_reg);
                    kind_lane[l]  = KIND_SUB1;
                    angle_lane[l] = d1 + a_reg;
                end
                else if (cyc_reg < CYC_W'(COMMON_START))
                begin
                    j             = 3'(cyc_reg - CYC_W'(SUB2_START));
                    kind_lane[l]  = KIND_SUB2;
                    angle_lane[l] = (d1 << 1) + b_reg;
                end
                else if (k < 4'(SUB2_START))
                begin
                    j             = 3'(k);
                    kind_lane[l]  = KIND_ADD1;
                    angle_lane[l] = a_reg - gj;
                end
                else if (k < 4'(COMMON_START))
                begin
                    j             = 3'(k - 4'(SUB2_START));
                    kind_lane[l]  = KIND_ADD2;
                    angle_lane[l] = b_reg - (gj << 1);
                end
            end

            pofn_sine #(.ANGLE_WIDTH(W)) u_sine
            (
                .clk   (clk),
                .angle (angle_lane[l]),
                .sine  (sine_lane[l])
            );

            assign contrib[l] = {{(ACC_W-32){sine_lane[l][31]}}, sine_lane[l]};
        end
    endgenerate

    always_comb
    begin
        tag_in       = '0;
        tag_in.valid = cur_valid_reg;
        tag_in.first = (cyc_reg == '0);
        tag_in.last  = last_cyc;
        tag_in.gain  = gain_reg;
        for (int n = 0; n < LANES; n++)
        begin
            tag_in.kind[n] = kind_lane[n];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < SINE_LAT; n++)
            begin
                tag_reg[n] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int n = 1; n < SINE_LAT; n++)
            begin
                tag_reg[n] <= tag_reg[n-1];
            end
        end
    end

    assign tag_out = tag_reg[SINE_LAT-1];

    // Accumulation of the sine results as they leave the pipelines.
    always_comb
    begin
        c1_next = tag_out.first ? '0 : c1_reg;
        c2_next = tag_out.first ? '0 : c2_reg;
        for (int n = 0; n < LANES; n++)
        begin
            acc1_next[n] = tag_out.first ? '0 : acc1_reg[n];
            acc2_next[n] = tag_out.first ? '0 : acc2_reg[n];
            case (tag_out.kind[n])
                KIND_SUB1: acc1_next[n] = acc1_next[n] - contrib[n];
                KIND_SUB2: acc2_next[n] = acc2_next[n] - contrib[n];
                default:   acc1_next[n] = acc1_next[n];
            endcase
        end
        for (int n = 0; n < LANES; n++)
        begin
            case (tag_out.kind[n])
                KIND_ADD1: c1_next = c1_next + contrib[n];
                KIND_ADD2: c2_next = c2_next + contrib[n];
                default:   c1_next = c1_next;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_out.valid)
        begin
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            for (int n = 0; n < LANES; n++)
            begin
                acc1_reg[n] <= acc1_next[n];
                acc2_reg[n] <= acc2_next[n];
            end
        end
    end

    // Final gain multiply, rounding and division by 320.
    always_comb
    begin
        for (int n = 0; n < LANES; n++)
        begin
            sum_c[n] = {{4{ph_reg[n][51]}}, ph_reg[n]} + {{19{pl_reg[n][52]}}, pl_reg[n][52:16]};
            v_c[n]   = $signed({{(56-ACC_W){s1b_reg[n][ACC_W-1]}}, s1b_reg[n]})
                       - (sum_c[n] >>> 12);
            mag_c[n] = (v_c[n][55] ? 56'(-v_c[n]) : 56'(v_c[n])) + 56'(ROUND_HALF);
            q_c[n]   = 64'(n_reg[n]) * 64'(DIV5_RECIP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin0_reg <= 1'b0;
            fin1_reg <= 1'b0;
            fin2_reg <= 1'b0;
            fin3_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fin0_reg <= tag_out.valid & tag_out.last;
            fin1_reg <= fin0_reg;
            fin2_reg <= fin1_reg;
            fin3_reg <= fin2_reg;
            done_reg <= fin3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_out.valid & tag_out.last)
        begin
            gain0_reg <= tag_out.gain;
        end
        if (fin0_reg)
        begin
            gain1_reg <= gain0_reg;
            for (int n = 0; n < LANES; n++)
            begin
                s1_reg[n] <= c1_reg + acc1_reg[n];
                s2_reg[n] <= c2_reg + acc2_reg[n];
            end
        end
        if (fin1_reg)
        begin
            for (int n = 0; n < LANES; n++)
            begin
                ph_reg[n]  <= $signed(gain1_reg[31:16]) * s2_reg[n];
                pl_reg[n]  <= $signed({1'b0, gain1_reg[15:0]}) * s2_reg[n];
                s1b_reg[n] <= s1_reg[n];
            end
        end
        if (fin2_reg)
        begin
            for (int n = 0; n < LANES; n++)
            begin
                n_reg[n]    <= mag_c[n][37:6];
                nneg_reg[n] <= v_c[n][55];
            end
        end
        if (fin3_reg)
        begin
            for (int n = 0; n < LANES; n++)
            begin
                res_reg[n] <= nneg_reg[n] ? -$signed({2'b00, q_c[n][63:34]})
                                          : $signed({2'b00, q_c[n][63:34]});
            end
        end
    end

    assign done              = done_reg;
    assign result.rate_one   = res_reg[0];
    assign result.rate_two   = res_reg[1];
    assign result.rate_three = res_reg[2];
    assign result.rate_four  = res_reg[3];

    assign status.issuing    = cur_valid_reg;
    assign status.last_issue = cur_valid_reg & last_cyc;

endmodule

`default_nettype wire

### rtl/phase_oscillator_network_rhs.sv
// A request passes the front register, the two-entry queue, the sequencer,
// the four shared sine pipelines, the accumulators and the final stages to done.
// Each request's fifty sines issue before the next request's first sine.
// A request is accepted while earlier ones are still in the sine pipelines.
// Results appear for one cycle on done; the receiver cannot stall them.
// Reset clears the three shift and gain registers to zero and empties all stages.
`timescale 1ns / 1ps
`default_nettype none

module phase_oscillator_network_rhs
    import pofn_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output logic             done,
    output result_t          result,
    input  wire logic        wr_en,
    input  wire cfg_index_t  wr_index,
    input  wire logic [31:0] wr_data
);

    localparam int QW = 6*ANGLE_WIDTH + 32;

    logic [31:0]   first_shift_reg, second_shift_reg, gain_reg;
    logic          push, pop, q_full, q_empty;
    logic [QW-1:0] push_data, pop_data;
    back_status_t  status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_shift_reg  <= '0;
            second_shift_reg <= '0;
            gain_reg         <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_FIRST_SHIFT:  first_shift_reg  <= wr_data;
                CFG_SECOND_SHIFT: second_shift_reg <= wr_data;
                CFG_SECOND_GAIN:  gain_reg         <= wr_data;
                default:          gain_reg         <= gain_reg;
            endcase
        end
    end

    pofn_front #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .first_shift  (first_shift_reg),
        .second_shift (second_shift_reg),
        .gain         (gain_reg),
        .q_full       (q_full),
        .busy         (busy),
        .push         (push),
        .push_data    (push_data)
    );

    pofn_queue #(.WIDTH(QW)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    pofn_back #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (pop_data),
        .pop     (pop),
        .done    (done),
        .result  (result),
        .status  (status)
    );

    a_result_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        status.last_issue |-> ##RESULT_LAT done)
        else $error("result did not follow the last issue cycle");

    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    a_issue_ends_cleanly: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(status.issuing) |-> $past(status.last_issue))
        else $error("issue stopped before the last cycle");

endmodule

`default_nettype wire
